[rtl/int32_to_float32_convert_defines.svh]
// Assertion macros for the checker file of the integer to float converter.
`ifndef INT32_TO_FLOAT32_CONVERT_DEFINES_SVH
`define INT32_TO_FLOAT32_CONVERT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define I2F_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("converter check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define I2F_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("converter check failed");

`endif

[rtl/i2f_pkg.sv]
// Package with the widths, constants and stage word types of the converter.
`default_nettype none

package i2f_pkg;

    // Field widths of the integer input and the single-precision result.
    localparam int Width    = 32;
    localparam int MantBits = 23;
    localparam int ExpBits  = 8;
    localparam int Bias     = 127;
    localparam int LzBits   = $clog2(Width);

    // The leading-zero count is built from byte-wide counts.
    localparam int Bytes       = Width / 8;
    localparam int ByteSelBits = $clog2(Bytes);

    // Position of the lowest kept mantissa bit after normalisation.
    localparam int FracLsb = Width - 1 - MantBits;

    // Biased exponent of a magnitude whose leading one sits at the top bit.
    localparam logic [ExpBits-1:0] ExpTop = ExpBits'(Bias + Width - 1);

    // Word after the sign and magnitude stage.
    typedef struct packed {
        logic             sign;
        logic [Width-1:0] mag;
    } abs_word_t;

    // Word after the leading-zero stage.
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [LzBits-1:0] lz;
        logic [Width-1:0]  mag;
    } lz_word_t;

    // Word after the normalising shift.
    typedef struct packed {
        logic               sign;
        logic [ExpBits-1:0] expo;
        logic [Width-1:0]   norm;
    } norm_word_t;

endpackage

`default_nettype wire

[rtl/i2f_channels.sv]
// Handshake channel interfaces for the integer input and the float result.
`default_nettype none

interface int_word_if;
    logic                       valid;
    logic                       ready;
    logic [i2f_pkg::Width-1:0]  int_value;

    modport source (output valid, output int_value, input ready);
    modport sink   (input valid, input int_value, output ready);
endinterface

interface float_word_if;
    logic                       valid;
    logic                       ready;
    logic [i2f_pkg::Width-1:0]  float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink   (input valid, input float_bits, output ready);
endinterface

`default_nettype wire

[rtl/i2f_abs_stage.sv]
// First pipeline stage: takes the sign and forms the magnitude.
`default_nettype none

module i2f_abs_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [i2f_pkg::Width-1:0]  int_value,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output i2f_pkg::abs_word_t         dn_word
);
    import i2f_pkg::*;

    logic      valid_reg;
    abs_word_t word_reg;
    abs_word_t word_next;

    // The stage takes a new word when it is empty or its word moves on.
    assign up_ready = !valid_reg || dn_ready;

    // Negative inputs are negated; the most negative value gives 2^31 unsigned.
    always_comb
    begin
        word_next.sign = int_value[Width-1];
        word_next.mag  = int_value[Width-1] ? (Width'(0) - int_value) : int_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

`default_nettype wire

[rtl/i2f_lzc_stage.sv]
// Second pipeline stage: counts the leading zeros of the magnitude.
`default_nettype none

module i2f_lzc_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  i2f_pkg::abs_word_t  up_word,
    output logic                dn_valid,
    input  logic                dn_ready,
    output i2f_pkg::lz_word_t   dn_word
);
    import i2f_pkg::*;

    logic                 valid_reg;
    lz_word_t             word_reg;
    lz_word_t             word_next;
    logic [Bytes-1:0]     byte_nz;
    logic [2:0]           byte_lz [Bytes];

    assign up_ready = !valid_reg || dn_ready;

    // Per-byte count: the highest set bit of each byte wins.
    always_comb
    begin
        for (int b = 0; b < Bytes; b++)
        begin
            byte_nz[b] = |up_word.mag[8*b +: 8];
            byte_lz[b] = 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                if (up_word.mag[8*b + i])
                begin
                    byte_lz[b] = 3'(7 - i);
                end
            end
        end
    end

    // The highest non-zero byte selects the full count.
    always_comb
    begin
        word_next.sign = up_word.sign;
        word_next.mag  = up_word.mag;
        word_next.zero = ~|byte_nz;
        word_next.lz   = '0;
        for (int b = 0; b < Bytes; b++)
        begin
            if (byte_nz[b])
            begin
                word_next.lz = {ByteSelBits'(Bytes - 1 - b), byte_lz[b]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

`default_nettype wire

[rtl/i2f_norm_stage.sv]
// Third pipeline stage: shifts the leading one to the top and forms the exponent.
`default_nettype none

module i2f_norm_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  i2f_pkg::lz_word_t   up_word,
    output logic                dn_valid,
    input  logic                dn_ready,
    output i2f_pkg::norm_word_t dn_word
);
    import i2f_pkg::*;

    logic       valid_reg;
    norm_word_t word_reg;
    norm_word_t word_next;

    assign up_ready = !valid_reg || dn_ready;

    // A zero magnitude keeps a zero exponent so that the result packs to zero.
    always_comb
    begin
        word_next.sign = up_word.sign;
        word_next.norm = up_word.mag << up_word.lz;
        word_next.expo = up_word.zero ? '0 : (ExpTop - ExpBits'(up_word.lz));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

`default_nettype wire

[rtl/i2f_round_stage.sv]
// Last pipeline stage: rounds the mantissa, packs the result and holds the output register.
`default_nettype none

module i2f_round_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  i2f_pkg::norm_word_t        up_word,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [i2f_pkg::Width-1:0]  float_bits
);
    import i2f_pkg::*;

    logic                       valid_reg;
    logic [Width-1:0]           bits_reg;
    logic [Width-1:0]           bits_next;
    logic [ExpBits+MantBits-1:0] packed_sum;

    assign up_ready = !valid_reg || dn_ready;

    // Round half away from zero on the highest dropped bit; a mantissa carry
    // ripples straight into the exponent field.
    always_comb
    begin
        packed_sum = {up_word.expo, up_word.norm[Width-2:FracLsb]}
                   + (ExpBits+MantBits)'(up_word.norm[FracLsb-1]);
        bits_next  = {up_word.sign, packed_sum};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            bits_reg <= bits_next;
        end
    end

    assign dn_valid   = valid_reg;
    assign float_bits = bits_reg;

endmodule

`default_nettype wire

[rtl/int32_to_float32_convert.sv]
// Top level of the signed 32-bit integer to single-precision float converter.
//
//   Channel    Role    Payload
//   in_word    sink    int_value  (32 bits, signed integer)
//   out_word   source  float_bits (32 bits, sign / exponent / mantissa)
//
// Four register stages: sign and magnitude, leading-zero count, normalising
// shift, then rounding and packing into the output register.
// A word is accepted every cycle while the output is not stalled; its result passes
// through each stage register in turn and can be taken from the output register.
// Each stage takes a new word whenever it is empty or its own word moves on,
// so a stall at the output fills the pipeline before in_word.ready falls.
// Reset clears only the stage valid bits; nothing else needs initialising.
`default_nettype none

module int32_to_float32_convert (
    input  logic                 clk,
    input  logic                 rst_n,
    int_word_if.sink             in_word,
    float_word_if.source         out_word
);
    import i2f_pkg::*;

    logic       abs_valid;
    logic       abs_ready;
    abs_word_t  abs_word;
    logic       lz_valid;
    logic       lz_ready;
    lz_word_t   lz_word;
    logic       norm_valid;
    logic       norm_ready;
    norm_word_t norm_word;

    // Sign and magnitude.
    i2f_abs_stage u_abs (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (in_word.valid),
        .up_ready  (in_word.ready),
        .int_value (in_word.int_value),
        .dn_valid  (abs_valid),
        .dn_ready  (abs_ready),
        .dn_word   (abs_word)
    );

    // Leading-zero count.
    i2f_lzc_stage u_lzc (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (abs_valid),
        .up_ready (abs_ready),
        .up_word  (abs_word),
        .dn_valid (lz_valid),
        .dn_ready (lz_ready),
        .dn_word  (lz_word)
    );

    // Normalising shift and exponent.
    i2f_norm_stage u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lz_valid),
        .up_ready (lz_ready),
        .up_word  (lz_word),
        .dn_valid (norm_valid),
        .dn_ready (norm_ready),
        .dn_word  (norm_word)
    );

    // Rounding, packing and the output register.
    i2f_round_stage u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (norm_valid),
        .up_ready   (norm_ready),
        .up_word    (norm_word),
        .dn_valid   (out_word.valid),
        .dn_ready   (out_word.ready),
        .float_bits (out_word.float_bits)
    );

endmodule

`default_nettype wire

[rtl/i2f_checker.sv]
// Port-level checker for the converter, bound to the top level.
`default_nettype none

`include "int32_to_float32_convert_defines.svh"

module i2f_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [i2f_pkg::Width-1:0]  float_bits
);
    import i2f_pkg::*;

    logic [ExpBits-1:0] out_expo;

    assign out_expo = float_bits[Width-2:MantBits];

    // A stalled result word keeps its value until taken.
    `I2F_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(float_bits))

    // No magnitude reaches beyond 2^31, so the exponent never passes one above ExpTop.
    `I2F_ASSERT_SAME(a_expo_range, out_valid, out_expo <= ExpTop + ExpBits'(1))

    // Only zero gives a zero exponent, and then the whole word is positive zero.
    `I2F_ASSERT_SAME(a_zero_form, out_valid && out_expo == '0, float_bits == '0)

    // Integers are whole numbers: no result lies below one in magnitude.
    `I2F_ASSERT_SAME(a_expo_floor, out_valid && out_expo != '0,
        out_expo >= ExpBits'(Bias))

endmodule

bind int32_to_float32_convert i2f_checker u_i2f_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_word.valid),
    .out_ready  (out_word.ready),
    .float_bits (out_word.float_bits)
);

`default_nettype wire
